[src/rect_circle_pixel_coverage_top_macros.svh]
// ============================================================================
// Assertion macros
// Shared forms for the concurrent assertions of the pixel coverage block.
// ============================================================================
`ifndef RECT_CIRCLE_PIXEL_COVERAGE_TOP_MACROS_SVH
`define RECT_CIRCLE_PIXEL_COVERAGE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcpc same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcpc next-cycle check failed");

`endif

[src/rcpc_pkg.sv]
// ============================================================================
// rcpc_pkg
// Types and constants shared by the rectangle and circle pixel coverage block.
// ============================================================================
package rcpc_pkg;

    // Default width of a pixel coordinate.
    localparam int COORD_BITS_DEF = 12;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register map, in word order.
    typedef enum logic [2:0] {
        REG_DISP_WIDTH   = 3'd0,
        REG_DISP_HEIGHT  = 3'd1,
        REG_PRIM_X       = 3'd2,
        REG_PRIM_Y       = 3'd3,
        REG_EXTENT_W     = 3'd4,
        REG_EXTENT_H     = 3'd5,
        REG_STROKE_SIZE  = 3'd6,
        REG_DRAW_COLOR   = 3'd7
    } reg_idx_t;

    // Primitive kinds carried by req_type.
    typedef enum logic [1:0] {
        KIND_FILL_RECT   = 2'd0,
        KIND_STROKE_RECT = 2'd1,
        KIND_FILL_CIRC   = 2'd2,
        KIND_STROKE_CIRC = 2'd3
    } kind_t;

    // Register file contents.
    typedef struct packed {
        logic [12:0] disp_width;
        logic [12:0] disp_height;
        logic [11:0] prim_x;
        logic [11:0] prim_y;
        logic [12:0] extent_w;
        logic [11:0] extent_h;
        logic [11:0] stroke_size;
        logic [31:0] draw_color;
    } cfg_t;

    // Values after reset.
    localparam cfg_t CFG_RESET = '{
        disp_width:   13'd640,
        disp_height:  13'd480,
        prim_x:       12'd0,
        prim_y:       12'd0,
        extent_w:     13'd0,
        extent_h:     12'd0,
        stroke_size:  12'd1,
        draw_color:   32'd0
    };

endpackage

[src/rcpc_ifs.sv]
// ============================================================================
// Pixel coverage channels
// Request channel (one pixel to test) and result channel (one pixel write).
// ============================================================================
interface rcpc_req_if #(
    parameter int COORD_BITS = rcpc_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;

    modport source (output valid, req_type, pix_x, pix_y, input ready);
    modport sink   (input valid, req_type, pix_x, pix_y, output ready);
endinterface

interface rcpc_res_if ();
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [23:0] pixel_offset;
    logic [31:0] pixel_color;

    modport source (output valid, write_enable, pixel_offset, pixel_color, input ready);
    modport sink   (input valid, write_enable, pixel_offset, pixel_color, output ready);
endinterface

[src/rcpc_pipe.sv]
// ============================================================================
// rcpc_pipe
// Three-register coverage pipeline: input word, products and rectangle test,
// then the circle compares and the result word.
// ============================================================================
module rcpc_pipe #(
    parameter int COORD_BITS = rcpc_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rcpc_pkg::cfg_t    cfg,
    rcpc_req_if.sink          req,
    rcpc_res_if.source        res
);

    // Working widths: distances, rectangle spans, squares, screen compare, product.
    localparam int DW = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int SW = DW + 3;
    localparam int QW = (2 * DW + 1 > 27) ? 2 * DW + 1 : 27;
    localparam int CW = (COORD_BITS > 13) ? COORD_BITS : 13;
    localparam int PW = COORD_BITS + 13;

    // True when lo <= p < lo + len.
    function automatic logic in_span(input logic [SW-1:0] p, input logic [SW-1:0] lo,
                                     input logic [SW-1:0] len);
        logic [SW-1:0] hi;
        hi = lo + len;
        return (p >= lo) && (p < hi);
    endfunction

    // Stage registers.
    logic                  s1_valid_reg, s1_valid_next;
    rcpc_pkg::kind_t       s1_kind_reg;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;

    logic                  s2_valid_reg, s2_valid_next;
    rcpc_pkg::kind_t       s2_kind_reg;
    logic                  s2_onscr_reg;
    logic                  s2_rect_reg;
    logic [2*DW-1:0]       s2_dx2_reg;
    logic [2*DW-1:0]       s2_dy2_reg;
    logic [25:0]           s2_r2_reg;
    logic [23:0]           s2_ls2_reg;
    logic [PW-1:0]         s2_prod_reg;
    logic [COORD_BITS-1:0] s2_x_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_we_reg;
    logic [23:0]           out_offset_reg;
    logic [31:0]           out_color_reg;

    logic s1_ready, s2_ready, s3_ready;

    // Each stage moves when it is empty or the stage after it moves.
    assign s3_ready  = !out_valid_reg || res.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    // First stage: distances, squares, offset product and rectangle coverage.
    logic [SW-1:0]   px_s, py_s, x_s, y_s, w_s, h_s, ls_s;
    logic            fill_hit, stroke_hit, rect_hit, onscr;
    logic [DW-1:0]   px_d, py_d, x_d, y_d, dx, dy;
    logic [2*DW-1:0] dx2, dy2;
    logic [25:0]     r2;
    logic [23:0]     ls2;
    logic [PW-1:0]   prod;

    assign px_s = SW'(s1_x_reg);
    assign py_s = SW'(s1_y_reg);
    assign x_s  = SW'(cfg.prim_x);
    assign y_s  = SW'(cfg.prim_y);
    assign w_s  = SW'(cfg.extent_w);
    assign h_s  = SW'(cfg.extent_h);
    assign ls_s = SW'(cfg.stroke_size);

    assign fill_hit = in_span(px_s, x_s, w_s) && in_span(py_s, y_s, h_s);

    // Stroked rectangle is the union of the top, bottom, left and right strips.
    assign stroke_hit =
        (in_span(px_s, x_s, w_s) && in_span(py_s, y_s, ls_s)) ||
        (in_span(px_s, x_s, w_s) && in_span(py_s, y_s + h_s, ls_s)) ||
        (in_span(px_s, x_s, ls_s) && in_span(py_s, y_s, h_s)) ||
        (in_span(px_s, x_s + w_s, ls_s) && in_span(py_s, y_s, h_s + ls_s));

    always_comb
    begin
        case (s1_kind_reg)
            rcpc_pkg::KIND_FILL_RECT:   rect_hit = fill_hit;
            rcpc_pkg::KIND_STROKE_RECT: rect_hit = stroke_hit;
            default:                    rect_hit = 1'b0;
        endcase
    end

    assign onscr = (CW'(s1_x_reg) < CW'(cfg.disp_width)) &&
                   (CW'(s1_y_reg) < CW'(cfg.disp_height));

    assign px_d = DW'(s1_x_reg);
    assign py_d = DW'(s1_y_reg);
    assign x_d  = DW'(cfg.prim_x);
    assign y_d  = DW'(cfg.prim_y);
    assign dx   = (px_d >= x_d) ? px_d - x_d : x_d - px_d;
    assign dy   = (py_d >= y_d) ? py_d - y_d : y_d - py_d;
    assign dx2  = (2 * DW)'(dx) * (2 * DW)'(dx);
    assign dy2  = (2 * DW)'(dy) * (2 * DW)'(dy);
    assign r2   = 26'(cfg.extent_w) * 26'(cfg.extent_w);
    assign ls2  = 24'(cfg.stroke_size) * 24'(cfg.stroke_size);
    assign prod = PW'(s1_y_reg) * PW'(cfg.disp_width);

    // Second stage: circle compares, write decision and offset sum.
    logic [QW-1:0] d2, r2_q, outer_q;
    logic          circ_hit, hit, we;

    assign d2      = QW'(s2_dx2_reg) + QW'(s2_dy2_reg);
    assign r2_q    = QW'(s2_r2_reg);
    assign outer_q = r2_q + QW'(s2_ls2_reg);

    always_comb
    begin
        case (s2_kind_reg)
            rcpc_pkg::KIND_FILL_CIRC:   circ_hit = (d2 <= r2_q);
            rcpc_pkg::KIND_STROKE_CIRC: circ_hit = (d2 >= r2_q) && (d2 <= outer_q);
            default:                    circ_hit = 1'b0;
        endcase
    end

    assign hit = s2_rect_reg || circ_hit;
    assign we  = s2_onscr_reg && hit;

    // Valid bits of the three stages.
    always_comb
    begin
        s1_valid_next  = s1_ready ? req.valid : s1_valid_reg;
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        out_valid_next = s3_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register.
    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_kind_reg <= rcpc_pkg::kind_t'(req.req_type);
            s1_x_reg    <= req.pix_x;
            s1_y_reg    <= req.pix_y;
        end
    end

    // Product and rectangle register.
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_onscr_reg <= onscr;
            s2_rect_reg  <= rect_hit;
            s2_dx2_reg   <= dx2;
            s2_dy2_reg   <= dy2;
            s2_r2_reg    <= r2;
            s2_ls2_reg   <= ls2;
            s2_prod_reg  <= prod;
            s2_x_reg     <= s1_x_reg;
        end
    end

    // Result word register; a pixel that is not written carries zeros.
    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            out_we_reg     <= we;
            out_offset_reg <= we ? 24'(s2_prod_reg) + 24'(s2_x_reg) : 24'd0;
            out_color_reg  <= we ? cfg.draw_color : 32'd0;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.write_enable = out_we_reg;
    assign res.pixel_offset = out_offset_reg;
    assign res.pixel_color  = out_color_reg;

endmodule

[src/rect_circle_pixel_coverage_top.sv]
// ============================================================================
// rect_circle_pixel_coverage_top
// Per-pixel coverage test for filled and stroked rectangles and circles.
// ============================================================================
// Each request word names one pixel and a primitive kind; the block answers
// with one result word saying whether that pixel is written, its linear
// framebuffer offset and the draw colour. A new pixel is taken every clock
// while the result side takes results, and each result passes through the
// three register stages of the pipeline (input word, squares and offset
// product, result word). Geometry, screen size, stroke width and colour are
// held in an APB register file and should only be changed while the block
// holds no pixel in flight.
module rect_circle_pixel_coverage_top #(
    parameter int COORD_BITS = rcpc_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcpc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    rcpc_req_if.sink                        req,
    rcpc_res_if.source                      res
);

    rcpc_pkg::cfg_t     cfg_reg;
    rcpc_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = rcpc_pkg::reg_idx_t'(paddr[rcpc_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes, masked to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rcpc_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                rcpc_pkg::REG_DISP_WIDTH:  cfg_reg.disp_width  <= pwdata[12:0];
                rcpc_pkg::REG_DISP_HEIGHT: cfg_reg.disp_height <= pwdata[12:0];
                rcpc_pkg::REG_PRIM_X:      cfg_reg.prim_x      <= pwdata[11:0];
                rcpc_pkg::REG_PRIM_Y:      cfg_reg.prim_y      <= pwdata[11:0];
                rcpc_pkg::REG_EXTENT_W:    cfg_reg.extent_w    <= pwdata[12:0];
                rcpc_pkg::REG_EXTENT_H:    cfg_reg.extent_h    <= pwdata[11:0];
                rcpc_pkg::REG_STROKE_SIZE: cfg_reg.stroke_size <= pwdata[11:0];
                rcpc_pkg::REG_DRAW_COLOR:  cfg_reg.draw_color  <= pwdata;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            rcpc_pkg::REG_DISP_WIDTH:  prdata = 32'(cfg_reg.disp_width);
            rcpc_pkg::REG_DISP_HEIGHT: prdata = 32'(cfg_reg.disp_height);
            rcpc_pkg::REG_PRIM_X:      prdata = 32'(cfg_reg.prim_x);
            rcpc_pkg::REG_PRIM_Y:      prdata = 32'(cfg_reg.prim_y);
            rcpc_pkg::REG_EXTENT_W:    prdata = 32'(cfg_reg.extent_w);
            rcpc_pkg::REG_EXTENT_H:    prdata = 32'(cfg_reg.extent_h);
            rcpc_pkg::REG_STROKE_SIZE: prdata = 32'(cfg_reg.stroke_size);
            rcpc_pkg::REG_DRAW_COLOR:  prdata = cfg_reg.draw_color;
            default:                   prdata = 32'd0;
        endcase
    end

    // Coverage pipeline.
    rcpc_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .res   (res)
    );

endmodule

[src/rcpc_checker.sv]
// ============================================================================
// rcpc_checker
// Port-level checks on the result channel of the pixel coverage block.
// ============================================================================
`include "rect_circle_pixel_coverage_top_macros.svh"

module rcpc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready,
    input logic [rcpc_pkg::APB_ADDR_W-1:0] paddr,
    input logic [rcpc_pkg::APB_DATA_W-1:0] pwdata,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            out_we,
    input logic [23:0]                     out_offset,
    input logic [31:0]                     out_color
);

    // Shadow of the draw colour as written over the configuration port.
    logic [31:0] exp_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_color_reg <= rcpc_pkg::CFG_RESET.draw_color;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[rcpc_pkg::APB_ADDR_W-1:2] == rcpc_pkg::REG_DRAW_COLOR))
        begin
            exp_color_reg <= pwdata;
        end
    end

    // A pixel that is not written carries a zero offset and colour.
    `RCPC_ASSERT_SAME(a_no_write_zero, out_valid && !out_we, (out_offset == 24'd0) && (out_color == 32'd0))

    // A written pixel carries the last colour written to the register file.
    `RCPC_ASSERT_SAME(a_write_color, out_valid && out_we, out_color == exp_color_reg)

    // A result that is not taken stays put.
    `RCPC_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(out_we) && $stable(out_offset) && $stable(out_color))

endmodule

bind rect_circle_pixel_coverage_top rcpc_checker u_rcpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_we     (res.write_enable),
    .out_offset (res.pixel_offset),
    .out_color  (res.pixel_color)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Pixel coverage testbench
// Drives pixel words into the rectangle and circle coverage block and checks
// every result word against a predictor kept in step with the register file.
// ============================================================================
module tb;
    import rcpc_pkg::*;

    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 26;

    // Expected contents of one result word.
    typedef struct packed {
        logic        write_enable;
        logic [23:0] pixel_offset;
        logic [31:0] pixel_color;
    } pixel_write_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    rcpc_req_if #(.COORD_BITS(COORD_BITS_DEF)) req_ch ();
    rcpc_res_if res_ch ();

    // Shadow of the register file, the queue of writes still to come out,
    // and the run bookkeeping.
    cfg_t         live_cfg;
    pixel_write_t pending_writes[$];
    bit           steady_flow;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    rect_circle_pixel_coverage_top #(.COORD_BITS(COORD_BITS_DEF)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    always #5 clk = ~clk;

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Half-open span test on both axes, in wide arithmetic so no sum wraps.
    function automatic bit in_area(input longint unsigned px, input longint unsigned py,
                                   input longint unsigned x0, input longint unsigned y0,
                                   input longint unsigned w, input longint unsigned h);
        return px >= x0 && px < x0 + w && py >= y0 && py < y0 + h;
    endfunction

    // Works out the result word for one pixel under the given registers.
    function automatic pixel_write_t predict_pixel(input cfg_t c, input kind_t kind,
                                                   input logic [11:0] px_in,
                                                   input logic [11:0] py_in);
        longint unsigned px, py, x, y, w, h, ls, dx, dy, d2, r2, lin;
        bit hit;
        pixel_write_t r;
        px = px_in;
        py = py_in;
        x  = c.prim_x;
        y  = c.prim_y;
        w  = c.extent_w;
        h  = c.extent_h;
        ls = c.stroke_size;
        case (kind)
            KIND_FILL_RECT:
                hit = in_area(px, py, x, y, w, h);
            KIND_STROKE_RECT:
                hit = in_area(px, py, x, y, w, ls) || in_area(px, py, x, y + h, w, ls) ||
                      in_area(px, py, x, y, ls, h) || in_area(px, py, x + w, y, ls, h + ls);
            default:
            begin
                dx = (px >= x) ? px - x : x - px;
                dy = (py >= y) ? py - y : y - py;
                d2 = dx * dx + dy * dy;
                r2 = w * w;
                if (kind == KIND_FILL_CIRC)
                    hit = d2 <= r2;
                else
                    hit = d2 >= r2 && d2 <= r2 + ls * ls;
            end
        endcase
        r = '0;
        if (hit && px < c.disp_width && py < c.disp_height)
        begin
            lin = py * c.disp_width + px;
            r.write_enable = 1'b1;
            r.pixel_offset = lin[23:0];
            r.pixel_color  = c.draw_color;
        end
        return r;
    endfunction

    // Result side: random back-pressure and the field-by-field check.
    always @(posedge clk)
    begin : result_check
        pixel_write_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_writes.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = pending_writes.pop_front();
                if (res_ch.write_enable !== want.write_enable)
                    report_mismatch($sformatf("write_enable got %b want %b",
                                              res_ch.write_enable, want.write_enable));
                if (res_ch.pixel_offset !== want.pixel_offset)
                    report_mismatch($sformatf("pixel_offset got %0d want %0d",
                                              res_ch.pixel_offset, want.pixel_offset));
                if (res_ch.pixel_color !== want.pixel_color)
                    report_mismatch($sformatf("pixel_color got %h want %h",
                                              res_ch.pixel_color, want.pixel_color));
            end
        end
        res_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // One APB write: setup, access until pready, then the bus is left quiet.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DISP_WIDTH:  live_cfg.disp_width  = value[12:0];
            REG_DISP_HEIGHT: live_cfg.disp_height = value[12:0];
            REG_PRIM_X:      live_cfg.prim_x      = value[11:0];
            REG_PRIM_Y:      live_cfg.prim_y      = value[11:0];
            REG_EXTENT_W:    live_cfg.extent_w    = value[12:0];
            REG_EXTENT_H:    live_cfg.extent_h    = value[11:0];
            REG_STROKE_SIZE: live_cfg.stroke_size = value[11:0];
            default:         live_cfg.draw_color  = value;
        endcase
    endtask

    task automatic set_shape(input logic [31:0] sw, input logic [31:0] sh,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] ls, input logic [31:0] color);
        write_reg(REG_DISP_WIDTH, sw);
        write_reg(REG_DISP_HEIGHT, sh);
        write_reg(REG_PRIM_X, x);
        write_reg(REG_PRIM_Y, y);
        write_reg(REG_EXTENT_W, w);
        write_reg(REG_EXTENT_H, h);
        write_reg(REG_STROKE_SIZE, ls);
        write_reg(REG_DRAW_COLOR, color);
    endtask

    // Offers one pixel word, with random idle cycles ahead of it, and records
    // the expected result once the word is taken.
    task automatic send_pixel(input kind_t kind, input logic [11:0] px, input logic [11:0] py);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.pix_x    <= px;
        req_ch.pix_y    <= py;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pending_writes.push_back(predict_pixel(live_cfg, kind, px, py));
    endtask

    // Stops traffic and waits until every result word is back.
    task automatic drain_pipeline();
        req_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Extent chooser biased towards small shapes, with both extremes.
    function automatic int pick_extent(input int top);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 0;
        if (roll < 10)
            return top;
        if (roll < 75)
            return $urandom_range(1, 48);
        return $urandom_range(0, top);
    endfunction

    // A pixel that mostly lands on or close to the current primitive.
    task automatic send_random_pixel();
        kind_t kind;
        int ddx, ddy, target, tx, ty, roll;
        logic [11:0] px, py;
        kind = kind_t'($urandom_range(3));
        roll = $urandom_range(99);
        if (roll < 30)
        begin
            px = 12'($urandom_range(4095));
            py = 12'($urandom_range(4095));
        end
        else if (kind == KIND_FILL_RECT || kind == KIND_STROKE_RECT)
        begin
            ddx = int'($urandom_range(0, live_cfg.extent_w + live_cfg.stroke_size + 6)) - 3;
            ddy = int'($urandom_range(0, live_cfg.extent_h + live_cfg.stroke_size + 6)) - 3;
            tx  = int'(live_cfg.prim_x) + ddx;
            ty  = int'(live_cfg.prim_y) + ddy;
            px  = tx[11:0];
            py  = ty[11:0];
        end
        else
        begin
            // Aim at the rim or the ring, or anywhere in the bounding square.
            if (roll < 70)
            begin
                target = int'(live_cfg.extent_w) + int'($urandom_range(0, live_cfg.stroke_size));
                ddx = $urandom_range(0, target);
                ddy = $rtoi($sqrt(real'(target) * target - real'(ddx) * ddx))
                      + int'($urandom_range(0, 2)) - 1;
            end
            else
            begin
                target = int'(live_cfg.extent_w) + int'(live_cfg.stroke_size) + 3;
                ddx = $urandom_range(0, target);
                ddy = $urandom_range(0, target);
            end
            if ($urandom_range(1))
                ddx = -ddx;
            if ($urandom_range(1))
                ddy = -ddy;
            tx = int'(live_cfg.prim_x) + ddx;
            ty = int'(live_cfg.prim_y) + ddy;
            px = tx[11:0];
            py = ty[11:0];
        end
        send_pixel(kind, px, py);
    endtask

    // A random register setting, the extremes among the choices.
    task automatic randomise_shape();
        int sw, sh, roll, xmax, ymax;
        logic [31:0] color;
        roll = $urandom_range(99);
        sw = (roll < 10) ? 4096 : (roll < 15) ? 8191 : (roll < 20) ? 1 : $urandom_range(64, 4096);
        roll = $urandom_range(99);
        sh = (roll < 10) ? 4096 : (roll < 15) ? 8191 : (roll < 20) ? 1 : $urandom_range(64, 4096);
        xmax = (sw > 4096) ? 4095 : sw - 1;
        ymax = (sh > 4096) ? 4095 : sh - 1;
        roll = $urandom_range(99);
        color = (roll < 10) ? 32'hFFFF_FFFF : (roll < 15) ? 32'h0 : $urandom;
        set_shape(sw, sh,
                  ($urandom_range(99) < 10) ? 4095 : $urandom_range(0, xmax),
                  ($urandom_range(99) < 10) ? 4095 : $urandom_range(0, ymax),
                  pick_extent(8191), pick_extent(4095), pick_extent(4095), color);
    endtask

    // Default registers: a zero-size primitive at the origin.
    task automatic test_reset_values();
        send_pixel(KIND_FILL_CIRC, 12'd0, 12'd0);
        send_pixel(KIND_STROKE_CIRC, 12'd1, 12'd0);
        send_pixel(KIND_FILL_RECT, 12'd0, 12'd0);
        send_pixel(KIND_STROKE_RECT, 12'd0, 12'd0);
        drain_pipeline();
    endtask

    // Edges of the filled rectangle and of each stroke strip.
    task automatic test_rectangles();
        set_shape(640, 480, 10, 20, 5, 4, 2, 32'hDEAD_BEEF);
        send_pixel(KIND_FILL_RECT, 12'd10, 12'd20);
        send_pixel(KIND_FILL_RECT, 12'd14, 12'd23);
        send_pixel(KIND_FILL_RECT, 12'd15, 12'd23);
        send_pixel(KIND_FILL_RECT, 12'd9, 12'd20);
        send_pixel(KIND_STROKE_RECT, 12'd11, 12'd21);
        send_pixel(KIND_STROKE_RECT, 12'd12, 12'd22);
        send_pixel(KIND_STROKE_RECT, 12'd16, 12'd25);
        send_pixel(KIND_STROKE_RECT, 12'd14, 12'd25);
        drain_pipeline();
    endtask

    // Points on, inside and just outside the disc and the ring.
    task automatic test_circles();
        set_shape(640, 480, 100, 100, 10, 0, 3, 32'h0000_00FF);
        send_pixel(KIND_FILL_CIRC, 12'd100, 12'd100);
        send_pixel(KIND_FILL_CIRC, 12'd90, 12'd100);
        send_pixel(KIND_FILL_CIRC, 12'd111, 12'd100);
        send_pixel(KIND_STROKE_CIRC, 12'd109, 12'd100);
        send_pixel(KIND_STROKE_CIRC, 12'd110, 12'd103);
        send_pixel(KIND_STROKE_CIRC, 12'd110, 12'd104);
        drain_pipeline();
    endtask

    // Zero screen width (written with junk above the field), offset wrap on an
    // oversized screen, and clipping on a one-row screen.
    task automatic test_screen_limits();
        set_shape(32'hFFFF_E000, 480, 0, 0, 8191, 4095, 4095, 32'h1234_5678);
        send_pixel(KIND_FILL_CIRC, 12'd0, 12'd0);
        drain_pipeline();
        set_shape(8191, 8191, 0, 0, 8191, 4095, 4095, 32'hFFFF_FFFF);
        send_pixel(KIND_FILL_RECT, 12'd4095, 12'd4095);
        send_pixel(KIND_FILL_CIRC, 12'd4095, 12'd4095);
        send_pixel(KIND_STROKE_CIRC, 12'd4095, 12'd0);
        drain_pipeline();
        set_shape(4096, 1, 4095, 0, 1, 1, 4095, 32'hA5A5_5A5A);
        send_pixel(KIND_FILL_RECT, 12'd4095, 12'd0);
        send_pixel(KIND_STROKE_RECT, 12'd4095, 12'd1);
        drain_pipeline();
    endtask

    // Many random settings, a burst of pixels under each.
    task automatic test_random_shapes();
        repeat (40)
        begin
            randomise_shape();
            repeat (25) send_random_pixel();
            drain_pipeline();
        end
    endtask

    // One long run at full rate with no idle cycles on either side.
    task automatic test_steady_stream();
        randomise_shape();
        steady_flow = 1'b1;
        repeat (250) send_random_pixel();
        drain_pipeline();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        live_cfg        = CFG_RESET;
        steady_flow     = 1'b0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= KIND_FILL_RECT;
        req_ch.pix_x    <= '0;
        req_ch.pix_y    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_rectangles();
        test_circles();
        test_screen_limits();
        test_random_shapes();
        test_steady_stream();

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[rect_circle_pixel_coverage_top.f]
+incdir+src
src/rcpc_pkg.sv
src/rcpc_ifs.sv
src/rcpc_pipe.sv
src/rect_circle_pixel_coverage_top.sv
src/rcpc_checker.sv
verif/tb.sv
